@@ rtl/eat_pkg.sv @@
`default_nettype none

package eat_pkg;

   // Width of elapsed time and alarm limit
   localparam int TIME_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REM_WIDTH = 20;
   // Wide enough for any saturating add or limit compare without loss
   localparam int WIDE_WIDTH = ((TIME_WIDTH > CSR_DATA_WIDTH) ? TIME_WIDTH : CSR_DATA_WIDTH) + 1;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [REM_WIDTH-1:0]  rem_type;
   typedef logic [WIDE_WIDTH-1:0] wide_type;

   localparam time_type TIME_MASK = '1;

   typedef enum logic [1:0] {
      MODE_STOPPED   = 2'd0,
      MODE_RUNNING   = 2'd1,
      MODE_TIMED_OUT = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_TICK_MS             = 3'd0,
      CSR_START_LIMIT_MS      = 3'd1,
      CSR_EXTEND_MS           = 3'd2,
      CSR_NOTIFY_INTERVAL_MS  = 3'd3,
      CSR_TIMEOUT_BURST_TICKS = 3'd4,
      CSR_NOTIFY_BURST_TICKS  = 3'd5,
      CSR_HEARTBEAT_TICKS     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0]         tick_ms;
      logic [31:0]         start_limit_ms;
      logic [23:0]         extend_ms;
      logic [REM_WIDTH-1:0] notify_interval_ms;
      logic [7:0]          timeout_burst_ticks;
      logic [7:0]          notify_burst_ticks;
      logic [7:0]          heartbeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic     alarm_led;
      logic     heartbeat_led;
      mode_type timer_mode;
   } result_type;

   localparam logic [15:0]          TICK_MS_RST             = 16'd250;
   localparam logic [31:0]          START_LIMIT_MS_RST      = 32'd60000;
   localparam logic [23:0]          EXTEND_MS_RST           = 24'd60000;
   localparam logic [REM_WIDTH-1:0] NOTIFY_INTERVAL_MS_RST  = 20'd10000;
   localparam logic [7:0]           TIMEOUT_BURST_TICKS_RST = 8'd60;
   localparam logic [7:0]           NOTIFY_BURST_TICKS_RST  = 8'd4;
   localparam logic [7:0]           HEARTBEAT_TICKS_RST     = 8'd4;

   // a + b, clipped at the top of the time range
   function automatic time_type sat_add(time_type a, logic [CSR_DATA_WIDTH-1:0] b);
      wide_type sum;
      sum = WIDE_WIDTH'(a) + WIDE_WIDTH'(b);
      return (sum >= WIDE_WIDTH'(TIME_MASK)) ? TIME_MASK : sum[TIME_WIDTH-1:0];
   endfunction

   // Fit a 32-bit limit into the time range
   function automatic time_type sat_limit(logic [CSR_DATA_WIDTH-1:0] v);
      wide_type wide_v;
      wide_v = WIDE_WIDTH'(v);
      return (wide_v > WIDE_WIDTH'(TIME_MASK)) ? TIME_MASK : wide_v[TIME_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/eat_csr.sv @@
`default_nettype none

module eat_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [eat_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output eat_pkg::cfg_type                         cfg
);

   eat_pkg::cfg_type cfg_ff;
   eat_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (eat_pkg::csr_index_type'(csr_index))
            eat_pkg::CSR_TICK_MS:             cfg_in.tick_ms = csr_wdata[15:0];
            eat_pkg::CSR_START_LIMIT_MS:      cfg_in.start_limit_ms = csr_wdata[31:0];
            eat_pkg::CSR_EXTEND_MS:           cfg_in.extend_ms = csr_wdata[23:0];
            eat_pkg::CSR_NOTIFY_INTERVAL_MS:
               cfg_in.notify_interval_ms = csr_wdata[eat_pkg::REM_WIDTH-1:0];
            eat_pkg::CSR_TIMEOUT_BURST_TICKS: cfg_in.timeout_burst_ticks = csr_wdata[7:0];
            eat_pkg::CSR_NOTIFY_BURST_TICKS:  cfg_in.notify_burst_ticks = csr_wdata[7:0];
            eat_pkg::CSR_HEARTBEAT_TICKS:     cfg_in.heartbeat_ticks = csr_wdata[7:0];
            default:                          cfg_in = cfg_ff;   // unmapped index: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms             <= eat_pkg::TICK_MS_RST;
         cfg_ff.start_limit_ms      <= eat_pkg::START_LIMIT_MS_RST;
         cfg_ff.extend_ms           <= eat_pkg::EXTEND_MS_RST;
         cfg_ff.notify_interval_ms  <= eat_pkg::NOTIFY_INTERVAL_MS_RST;
         cfg_ff.timeout_burst_ticks <= eat_pkg::TIMEOUT_BURST_TICKS_RST;
         cfg_ff.notify_burst_ticks  <= eat_pkg::NOTIFY_BURST_TICKS_RST;
         cfg_ff.heartbeat_ticks     <= eat_pkg::HEARTBEAT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/eat_step.sv @@
`default_nettype none

module eat_step (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire logic          start_level,
   input  wire logic          extend_level,
   input  wire eat_pkg::cfg_type cfg,
   output eat_pkg::result_type result
);

   logic                prev_start_ff,   prev_start_in;
   logic                prev_extend_ff,  prev_extend_in;
   eat_pkg::mode_type   mode_ff,         mode_in;
   eat_pkg::time_type   elapsed_ff,      elapsed_in;
   eat_pkg::time_type   limit_ff,        limit_in;
   eat_pkg::rem_type    rem_ff,          rem_in;
   logic [7:0]          burst_ff,        burst_in;
   logic [7:0]          hb_count_ff,     hb_count_in;
   logic                alarm_led_ff,    alarm_led_in;
   logic                hb_led_ff,       hb_led_in;

   eat_pkg::rem_type          interval;
   logic [eat_pkg::REM_WIDTH:0] rem_sum;

   always_comb begin
      prev_start_in  = start_level;
      prev_extend_in = extend_level;
      mode_in        = mode_ff;
      elapsed_in     = elapsed_ff;
      limit_in       = limit_ff;
      rem_in         = rem_ff;
      burst_in       = burst_ff;
      hb_led_in      = hb_led_ff;
      alarm_led_in   = alarm_led_ff;

      // start / stop edge
      if (start_level != prev_start_ff) begin
         if (start_level) begin
            mode_in    = eat_pkg::MODE_RUNNING;
            elapsed_in = '0;
            rem_in     = '0;
            limit_in   = eat_pkg::sat_limit(cfg.start_limit_ms);
         end else begin
            mode_in  = eat_pkg::MODE_STOPPED;
            burst_in = '0;
         end
      end

      // extend edge counts only while running
      if (extend_level && !prev_extend_ff && (mode_in == eat_pkg::MODE_RUNNING)) begin
         limit_in = eat_pkg::sat_add(limit_in, eat_pkg::CSR_DATA_WIDTH'(cfg.extend_ms));
      end

      // interval is never below one tick
      interval = (cfg.notify_interval_ms < eat_pkg::REM_WIDTH'(cfg.tick_ms))
               ? eat_pkg::REM_WIDTH'(cfg.tick_ms) : cfg.notify_interval_ms;
      rem_sum  = (eat_pkg::REM_WIDTH+1)'(rem_in) + (eat_pkg::REM_WIDTH+1)'(cfg.tick_ms);
      if (rem_sum >= (eat_pkg::REM_WIDTH+1)'(interval)) begin
         rem_sum = rem_sum - (eat_pkg::REM_WIDTH+1)'(interval);
      end

      unique case (mode_in)
         eat_pkg::MODE_RUNNING: begin
            if (elapsed_in >= limit_in) begin
               burst_in = cfg.timeout_burst_ticks;
               mode_in  = eat_pkg::MODE_TIMED_OUT;
            end else if (rem_in == '0) begin
               burst_in = cfg.notify_burst_ticks;
            end
            elapsed_in = eat_pkg::sat_add(elapsed_in, eat_pkg::CSR_DATA_WIDTH'(cfg.tick_ms));
            rem_in     = rem_sum[eat_pkg::REM_WIDTH-1:0];
         end
         default: mode_in = eat_pkg::MODE_STOPPED;
      endcase

      // heartbeat; a period of zero acts as one
      hb_count_in = hb_count_ff + 8'd1;
      if (hb_count_in >= cfg.heartbeat_ticks) begin
         hb_led_in   = !hb_led_ff;
         hb_count_in = '0;
      end

      if (burst_in != '0) begin
         alarm_led_in = !alarm_led_ff;
         burst_in     = burst_in - 8'd1;
      end else begin
         alarm_led_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_start_ff  <= 1'b0;
         prev_extend_ff <= 1'b0;
         mode_ff        <= eat_pkg::MODE_STOPPED;
         elapsed_ff     <= '0;
         limit_ff       <= '0;
         rem_ff         <= '0;
         burst_ff       <= '0;
         hb_count_ff    <= '0;
         alarm_led_ff   <= 1'b0;
         hb_led_ff      <= 1'b0;
      end else if (step_en) begin
         prev_start_ff  <= prev_start_in;
         prev_extend_ff <= prev_extend_in;
         mode_ff        <= mode_in;
         elapsed_ff     <= elapsed_in;
         limit_ff       <= limit_in;
         rem_ff         <= rem_in;
         burst_ff       <= burst_in;
         hb_count_ff    <= hb_count_in;
         alarm_led_ff   <= alarm_led_in;
         hb_led_ff      <= hb_led_in;
      end
   end

   assign result.alarm_led     = alarm_led_in;
   assign result.heartbeat_led = hb_led_in;
   assign result.timer_mode    = mode_in;

   // timed-out lasts exactly one tick
   a_timeout_one_tick: assert property (@(posedge clock) disable iff (reset)
      (step_en && (mode_ff == eat_pkg::MODE_TIMED_OUT)) |=> (mode_ff == eat_pkg::MODE_STOPPED))
      else $error("timed-out mode held past one tick");

   // any active mode needs the start switch on
   a_active_needs_start: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != eat_pkg::MODE_STOPPED) |-> prev_start_ff)
      else $error("timer active with start switch off");

   // a stop edge cancels the burst and stops the timer
   a_stop_cancels: assert property (@(posedge clock) disable iff (reset)
      (step_en && !start_level && prev_start_ff)
      |=> ((burst_ff == '0) && (mode_ff == eat_pkg::MODE_STOPPED) && !alarm_led_ff))
      else $error("stop edge left burst or mode active");

endmodule

`default_nettype wire

@@ rtl/extendable_alarm_timer.sv @@
`default_nettype none

// Extendable alarm timer. Each req_ transfer is one periodic tick carrying the
// start and extend switch levels; each tick yields exactly one rsp_ transfer
// with the alarm LED, heartbeat LED and timer mode after that tick. A tick
// sits in an input register, then update logic advances the timer state and
// loads the result register; one tick is taken every cycle unless rsp_stall
// holds the result register. The result register lets a new tick in while a
// finished result still waits on rsp_stall. The user must write registers
// through csr_ only while no tick is in flight; the block does not enforce
// this. An index past the last register is dropped. Reset clears the timer
// to stopped with both switches taken as off and loads the register defaults.
module extendable_alarm_timer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tick input
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic                               req_start_level,
   input  wire logic                               req_extend_level,
   // result output
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic                               rsp_alarm_led,
   output      logic                               rsp_heartbeat_led,
   output      logic [1:0]                         rsp_timer_mode,
   // register writes
   input  wire logic                               csr_write_en,
   input  wire logic [2:0]                         csr_index,
   input  wire logic [eat_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   eat_pkg::cfg_type    cfg;
   eat_pkg::result_type step_result;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_start_ff;
   logic in_extend_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   eat_pkg::result_type rsp_data_ff;

   logic out_open;   // result register free this cycle
   logic step_en;    // tick moves from input to result register
   logic req_take;

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   // hold the input stage until the tick advances; refill in the same cycle
   assign in_valid_in  = req_take || (in_valid_ff && !step_en);
   // keep a result until it is taken
   assign rsp_valid_in = step_en || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: capture on transfer only
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_start_ff  <= req_start_level;
         in_extend_ff <= req_extend_level;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   eat_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   eat_step u_step (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .start_level  (in_start_ff),
      .extend_level (in_extend_ff),
      .cfg          (cfg),
      .result       (step_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alarm_led     = rsp_data_ff.alarm_led;
   assign rsp_heartbeat_led = rsp_data_ff.heartbeat_led;
   assign rsp_timer_mode    = rsp_data_ff.timer_mode;

   // a held tick is not lost while the result side is blocked
   a_tick_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_open) |=> in_valid_ff)
      else $error("pending tick dropped while result stalled");

   // a blocked result is not overwritten by an advancing tick
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !step_en)
      else $error("tick advanced into an occupied result register");

   // each advancing tick shows up as a result next cycle
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("advanced tick produced no result");

endmodule

`default_nettype wire
